// ----- src/min_tracking_stack_core_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- src/mts_pkg.sv -----
package mts_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 128;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 104;
    localparam int OUT_TUSER_W   = 2;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Shift control broadcast to every cell of a chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

// ----- src/mts_cell.sv -----
module mts_cell
    import mts_pkg::*;
(
    input  logic       i_clk,
    input  t_shift_ctl i_ctl,
    input  t_word      i_from_above,
    input  t_word      i_from_below,
    output t_word      o_word
);

    t_word r_word;
    t_word n_word;

    // Push moves words one place deeper, pop one place toward the top.
    always_comb begin
        n_word = r_word;
        if (i_ctl.push) begin
            n_word = i_from_above;
        end else if (i_ctl.pop) begin
            n_word = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- src/mts_chain.sv -----
module mts_chain
    import mts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  t_shift_ctl i_ctl,
    input  t_word      i_value,
    output t_word      o_top0,
    output t_word      o_top1
);

    t_word w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_above;
        t_word w_below;

        if (g == 0) begin : g_first
            assign w_above = i_value;
        end else begin : g_mid_above
            assign w_above = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_below = '0;
        end else begin : g_mid_below
            assign w_below = w_cell[g+1];
        end

        mts_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_word       (w_cell[g])
        );
    end

    assign o_top0 = w_cell[0];
    assign o_top1 = w_cell[1];

endmodule

// ----- src/min_tracking_stack_core.sv -----
// Min-tracking stack: a LIFO of signed 32-bit words that reports its minimum.
// Input channel s_axis: one transaction is one command. tuser[0] is the command
// (0 push, 1 pop), tdata[31:0] the word to push (ignored on pop).
// Output channel m_axis: exactly one result transaction per command, in order.
// tdata holds popped word, top word, current minimum and the empty flag;
// tuser holds the status (ok, push refused when full, pop refused when empty).
// Refused commands leave the stack untouched.
// Storage is two chains of DEPTH cells, one for the words and one for the run
// of minima; the top entry lives in cell 0 and each shift of a chain moves
// the whole chain by one place, all cells together.
// The result is registered and shows in the cycle after acceptance.
// One command is taken per cycle while s_axis_tready is high.
// A stalled result holds in the output register; s_axis_tready drops only
// while that register is full and m_axis_tready is low.
// Reset (synchronous, active low) empties both stacks and the output register;
// cell contents are not cleared, entries are read only below the counts.
module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [0:0]             s_axis_tuser,   // [0] command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] popped_value, [63:32] top_value,
                                                   // [95:64] current_min, [96] stack_empty,
                                                   // [103:97] zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_min_count;
    logic [CNT_W-1:0] n_min_count;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;
    t_status                r_out_status;
    t_status                n_out_status;

    t_shift_ctl w_data_ctl;
    t_shift_ctl w_min_ctl;
    t_word      w_data_top0;
    t_word      w_data_top1;
    t_word      w_min_top0;
    t_word      w_min_top1;

    logic  w_accept;
    t_cmd  w_cmd;
    t_word w_value;
    logic  w_push_ok;
    logic  w_pop_ok;
    logic  w_min_push;
    logic  w_min_pop;
    t_word w_popped;
    t_word w_top_after;
    t_word w_min_after;

    // Take a new command whenever the output register is free or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = t_cmd'(s_axis_tuser[0]);
    assign w_value       = t_word'(s_axis_tdata[WORD_W-1:0]);

    assign w_push_ok = w_accept && (w_cmd == CMD_PUSH) && (r_count != CNT_FULL);
    assign w_pop_ok  = w_accept && (w_cmd == CMD_POP) && (r_count != '0);

    // A word at or below the current minimum opens a new minima entry;
    // popping a word equal to the current minimum retires that entry.
    assign w_min_push = w_push_ok && ((r_min_count == '0) || (w_value <= w_min_top0));
    assign w_min_pop  = w_pop_ok && (r_min_count != '0) && (w_data_top0 == w_min_top0);

    assign w_data_ctl = '{push: w_push_ok, pop: w_pop_ok};
    assign w_min_ctl  = '{push: w_min_push, pop: w_min_pop};

    mts_chain #(
        .DEPTH (DEPTH)
    ) u_data_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_data_ctl),
        .i_value (w_value),
        .o_top0  (w_data_top0),
        .o_top1  (w_data_top1)
    );

    mts_chain #(
        .DEPTH (DEPTH)
    ) u_min_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_min_ctl),
        .i_value (w_value),
        .o_top0  (w_min_top0),
        .o_top1  (w_min_top1)
    );

    // Look through the chain shift so the result reflects the state after it.
    always_comb begin
        w_popped = w_pop_ok ? w_data_top0 : '0;

        if (w_push_ok) begin
            w_top_after = w_value;
        end else if (w_pop_ok) begin
            w_top_after = (r_count > CNT_ONE) ? w_data_top1 : '0;
        end else begin
            w_top_after = (r_count != '0) ? w_data_top0 : '0;
        end

        if (w_min_push) begin
            w_min_after = w_value;
        end else if (w_min_pop) begin
            w_min_after = (r_min_count > CNT_ONE) ? w_min_top1 : INT_MAX;
        end else begin
            w_min_after = (r_min_count != '0) ? w_min_top0 : INT_MAX;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_min_count = r_min_count;
        if (w_push_ok) begin
            n_count = r_count + CNT_ONE;
        end else if (w_pop_ok) begin
            n_count = r_count - CNT_ONE;
        end
        if (w_min_push) begin
            n_min_count = r_min_count + CNT_ONE;
        end else if (w_min_pop) begin
            n_min_count = r_min_count - CNT_ONE;
        end
    end

    // Output register: load on accept, drop once the receiver takes it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_data  = {7'd0, (n_count == '0), w_min_after, w_top_after, w_popped};
            if (w_cmd == CMD_PUSH) begin
                n_out_status = w_push_ok ? STATUS_OK : STATUS_FULL;
            end else begin
                n_out_status = w_pop_ok ? STATUS_OK : STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_min_count <= n_min_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

// ----- src/mts_checker.sv -----
`include "min_tracking_stack_core_assert.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [0:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    t_word w_top;
    t_word w_min;
    logic  w_empty;

    assign w_top   = t_word'(m_axis_tdata[63:32]);
    assign w_min   = t_word'(m_axis_tdata[95:64]);
    assign w_empty = m_axis_tdata[96];

    // An empty stack shows no top word and the largest word as minimum.
    `MTS_ASSERT_IMPLY(a_empty_view, i_clk, i_rst_n, m_axis_tvalid && w_empty, (w_top == '0) && (w_min == INT_MAX))

    // The minimum never exceeds the top entry it covers.
    `MTS_ASSERT_IMPLY(a_min_le_top, i_clk, i_rst_n, m_axis_tvalid && !w_empty, w_min <= w_top)

    // A refused pop means the stack was and stays empty, with nothing popped.
    `MTS_ASSERT_IMPLY(a_pop_refused, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY), w_empty && (m_axis_tdata[31:0] == '0))

    // A refused push means the stack is full, so never empty.
    `MTS_ASSERT_IMPLY(a_push_refused, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == STATUS_FULL), !w_empty)

    // A stalled result holds.
    `MTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);
